### sv/scdsp_pkg.sv
// Shared constants, types and state encoding for the scope capture decimator.
package scdsp_pkg;

	localparam int CAPTURE_LEN     = 15000;
	localparam int DISPLAY_SAMPLES = 200;

	localparam int SAMPLE_W = 8;
	localparam int TDIV_W   = 5;
	localparam int VDIV_W   = 8;
	localparam int POS_W    = 14;
	localparam int PHASE_W  = 4;
	localparam int KEPT_W   = 8;
	localparam int VALUE_W  = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	// trace numerator and restoring divider sizes
	localparam int NUM_W     = 23;
	localparam int QUOT_W    = 14;
	localparam int DIV_STEPS = QUOT_W;
	localparam int DCNT_W    = 4;

	localparam int MAX_STEP = 16;

	localparam logic [CFG_IDX_W-1:0] REG_TIME_DIV  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_VOLTS_DIV = 1'b1;

	localparam logic KIND_TRACE = 1'b0;
	localparam logic KIND_PEAK  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NUM,
		ST_DIV,
		ST_TRACE,
		ST_PEAK
	} state_t;

	typedef struct packed {
		logic take_item;
		logic load_num;
		logic div_step;
		logic load_trace;
		logic load_peak;
	} ctl_cmd_t;

	typedef struct packed {
		logic keep_now;
		logic end_now;
		logic end_q;
		logic div_last;
		logic out_free;
	} dp_status_t;

endpackage

### sv/scope_capture_decimate_scale_peak_unit.sv
// A kept sample passes through the numerator load, 14 divide steps and the trace load,
// which waits while out_stall holds the output register; no new sample is taken meanwhile.
// The restoring divider yields one quotient bit per cycle. Dropped samples are taken
// back to back; a capture's last sample is followed by the peak item load.
// One result register parts the output; the next item is taken while it waits.
// Reset (arst_n low) clears counters, peak, output valid; time_div 2, volts_div 100.
module scope_capture_decimate_scale_peak_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [scdsp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [scdsp_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [scdsp_pkg::SAMPLE_W-1:0]       adc_sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 kind,
	output logic signed [scdsp_pkg::VALUE_W-1:0] value,
	output logic [scdsp_pkg::KEPT_W-1:0]         position,
	output logic                                 last
);
	import scdsp_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t st;

	scdsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	scdsp_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.adc_sample (adc_sample),
		.cmd        (cmd),
		.st         (st),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.value      (value),
		.position   (position),
		.last       (last)
	);

endmodule

### sv/scdsp_ctrl.sv
// Controller state machine sequencing accept, divide and result loads.
module scdsp_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  scdsp_pkg::dp_status_t  st,
	output scdsp_pkg::ctl_cmd_t    cmd
);
	import scdsp_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (st.keep_now) begin
						state_d = ST_NUM;
					end else if (st.end_now) begin
						state_d = ST_PEAK;
					end
				end
			end
			ST_NUM: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (st.div_last) begin
					state_d = ST_TRACE;
				end
			end
			ST_TRACE: begin
				if (st.out_free) begin
					state_d = st.end_q ? ST_PEAK : ST_IDLE;
				end
			end
			ST_PEAK: begin
				if (st.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall       = (state_q != ST_IDLE);
		cmd.take_item  = (state_q == ST_IDLE) && in_valid;
		cmd.load_num   = (state_q == ST_NUM);
		cmd.div_step   = (state_q == ST_DIV);
		cmd.load_trace = (state_q == ST_TRACE) && st.out_free;
		cmd.load_peak  = (state_q == ST_PEAK) && st.out_free;
	end

endmodule

### sv/scdsp_dp.sv
// Datapath: capture counters, peak tracking, trace divider and output register.
module scdsp_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [scdsp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [scdsp_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [scdsp_pkg::SAMPLE_W-1:0]       adc_sample,
	input  scdsp_pkg::ctl_cmd_t                  cmd,
	output scdsp_pkg::dp_status_t                st,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 kind,
	output logic signed [scdsp_pkg::VALUE_W-1:0] value,
	output logic [scdsp_pkg::KEPT_W-1:0]         position,
	output logic                                 last
);
	import scdsp_pkg::*;

	localparam logic [POS_W-1:0]  CAPTURE_LEN_C = POS_W'(CAPTURE_LEN);
	localparam logic [KEPT_W-1:0] DISPLAY_C     = KEPT_W'(DISPLAY_SAMPLES);
	localparam logic [TDIV_W-1:0] MAX_STEP_C    = TDIV_W'(MAX_STEP);
	localparam logic signed [NUM_W-1:0] TRACE_GAIN = NUM_W'(4200);
	localparam logic [20:0] VOLT_GAIN = 21'd7680;
	localparam logic [16:0] PEAK_MV_GAIN = 17'd500;
	localparam logic [8:0]  PEAK_OFFSET = 9'd250;
	// 22 * 52429 / 2^18 stands for 44 / 10 over the peak range
	localparam logic [20:0] PEAK_GAIN = 21'd1153438;
	localparam int PEAK_SHIFT = 18;
	localparam logic [QUOT_W-1:0] SAT_POS = QUOT_W'(2047);
	localparam logic [QUOT_W-1:0] SAT_NEG = QUOT_W'(2048);

	// configuration
	logic [TDIV_W-1:0] time_div_q;
	logic [VDIV_W-1:0] volts_div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_div_q  <= TDIV_W'(2);
			volts_div_q <= VDIV_W'(100);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIME_DIV:  time_div_q  <= cfg_data[TDIV_W-1:0];
				REG_VOLTS_DIV: volts_div_q <= cfg_data[VDIV_W-1:0];
				default: ;
			endcase
		end
	end

	logic [TDIV_W-1:0] step_c;
	logic [VDIV_W-1:0] vdiv_c;

	always_comb begin
		if (time_div_q == '0) begin
			step_c = TDIV_W'(1);
		end else if (time_div_q > MAX_STEP_C) begin
			step_c = MAX_STEP_C;
		end else begin
			step_c = time_div_q;
		end
		vdiv_c = (volts_div_q == '0) ? VDIV_W'(1) : volts_div_q;
	end

	// capture bookkeeping
	logic [POS_W-1:0]    pos_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [KEPT_W-1:0]   kept_q;
	logic [SAMPLE_W-1:0] peak_q;

	logic [SAMPLE_W-1:0] peak_new_c;
	logic [POS_W-1:0]    pos_next_c;
	logic [TDIV_W-1:0]   phase_inc_c;
	logic                keep_c;
	logic                end_c;

	always_comb begin
		peak_new_c  = (adc_sample > peak_q) ? adc_sample : peak_q;
		keep_c      = (phase_q == '0) && (kept_q < DISPLAY_C);
		pos_next_c  = pos_q + POS_W'(1);
		end_c       = (pos_next_c >= CAPTURE_LEN_C) || (pos_next_c == '0);
		phase_inc_c = TDIV_W'(phase_q) + TDIV_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= '0;
			kept_q  <= '0;
			peak_q  <= '0;
		end else if (cmd.take_item) begin
			if (end_c) begin
				pos_q   <= '0;
				phase_q <= '0;
				kept_q  <= '0;
				peak_q  <= '0;
			end else begin
				pos_q   <= pos_next_c;
				phase_q <= (phase_inc_c >= step_c) ? '0 : phase_inc_c[PHASE_W-1:0];
				kept_q  <= kept_q + KEPT_W'(keep_c);
				peak_q  <= peak_new_c;
			end
		end
	end

	// per-item holding registers
	logic                end_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [KEPT_W-1:0]   trace_pos_q;
	logic [7:0]          peak_d_q;

	logic [16:0] peak_mv_prod_c;
	logic [8:0]  peak_mv_c;
	logic [8:0]  peak_d_c;

	always_comb begin
		peak_mv_prod_c = 17'(peak_new_c) * PEAK_MV_GAIN;
		peak_mv_c      = peak_mv_prod_c[16:8];
		peak_d_c       = (peak_mv_c > PEAK_OFFSET) ? (peak_mv_c - PEAK_OFFSET) : 9'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_q <= 1'b0;
		end else if (cmd.take_item) begin
			end_q <= end_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			sample_q    <= adc_sample;
			trace_pos_q <= kept_q;
			peak_d_q    <= peak_d_c[7:0];
		end
	end

	// trace numerator: (s - 128) * 4200 + 7680 * v
	logic signed [9:0]       sm_c;
	logic signed [NUM_W-1:0] sm_ext_c;
	logic [20:0]             vterm_c;
	logic signed [NUM_W-1:0] num_c;
	logic [NUM_W-1:0]        mag_c;

	always_comb begin
		sm_c     = $signed({2'b00, sample_q}) - 10'sd128;
		sm_ext_c = NUM_W'(sm_c);
		vterm_c  = 21'(vdiv_c) * VOLT_GAIN;
		num_c    = sm_ext_c * TRACE_GAIN + $signed(NUM_W'(vterm_c));
		mag_c    = num_c[NUM_W-1] ? NUM_W'(-num_c) : NUM_W'(num_c);
	end

	// restoring divider: |num| / 256 / v, one quotient bit per cycle
	logic              neg_q;
	logic [QUOT_W-1:0] dvd_q;
	logic [VDIV_W-1:0] rem_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [VDIV_W:0]   rem_shift_c;
	logic              ge_c;

	always_comb begin
		rem_shift_c = {rem_q, dvd_q[QUOT_W-1]};
		ge_c        = (rem_shift_c >= {1'b0, vdiv_c});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.load_num) begin
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_num) begin
			neg_q <= num_c[NUM_W-1];
			dvd_q <= mag_c[QUOT_W+7:8];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge_c ? VDIV_W'(rem_shift_c - {1'b0, vdiv_c}) : rem_shift_c[VDIV_W-1:0];
			dvd_q <= {dvd_q[QUOT_W-2:0], ge_c};
		end
	end

	// saturate and sign the quotient
	logic signed [VALUE_W-1:0] trace_val_c;
	logic [QUOT_W-1:0]         quot_neg_c;

	always_comb begin
		quot_neg_c = QUOT_W'(-dvd_q);
		if (neg_q) begin
			trace_val_c = (dvd_q > SAT_NEG) ? $signed(SAT_NEG[VALUE_W-1:0] ^ '0)
			                                : $signed(quot_neg_c[VALUE_W-1:0]);
			if (dvd_q > SAT_NEG) begin
				trace_val_c = -12'sd2048;
			end
		end else begin
			trace_val_c = (dvd_q > SAT_POS) ? 12'sd2047 : $signed(dvd_q[VALUE_W-1:0]);
		end
	end

	// peak value
	logic [28:0]        peak_prod_c;
	logic [VALUE_W-1:0] peak_val_c;

	always_comb begin
		peak_prod_c = 29'(peak_d_q) * 29'(PEAK_GAIN);
		peak_val_c  = VALUE_W'(peak_prod_c >> PEAK_SHIFT);
	end

	// output register
	logic                      out_valid_q;
	logic                      kind_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [KEPT_W-1:0]         position_q;
	logic                      last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_trace || cmd.load_peak) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_trace) begin
			kind_q     <= KIND_TRACE;
			value_q    <= trace_val_c;
			position_q <= trace_pos_q;
			last_q     <= 1'b0;
		end else if (cmd.load_peak) begin
			kind_q     <= KIND_PEAK;
			value_q    <= $signed(peak_val_c);
			position_q <= '0;
			last_q     <= 1'b1;
		end
	end

	always_comb begin
		st.keep_now = keep_c;
		st.end_now  = end_c;
		st.end_q    = end_q;
		st.div_last = (dcnt_q == DCNT_W'(DIV_STEPS - 1));
		st.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign value     = value_q;
	assign position  = position_q;
	assign last      = last_q;

endmodule

### dv/tb_scope_capture_decimate_scale_peak_unit.sv
// Self-checking testbench for the scope capture decimator with peak detect.
module tb_scope_capture_decimate_scale_peak_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import scdsp_pkg::*;

	localparam int MIDSCALE      = 128;
	localparam int TRACE_GAIN    = 4200;
	localparam int TRACE_OFFSET  = 7680;
	localparam int PEAK_OFFSET   = 250;
	localparam int DRAIN_CYCLES  = 24;
	localparam int RANDOM_ITEMS  = 1750;
	localparam int PRINT_LIMIT   = 100;

	typedef struct packed {
		logic                kind;
		logic [VALUE_W-1:0]  value;
		logic [KEPT_W-1:0]   position;
		logic                last;
	} scope_result_t;

	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_COIN} rx_mode_e;
	typedef enum int {SMP_UNIFORM, SMP_MIDSCALE, SMP_RAILS, SMP_LOWER} sample_style_e;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_index = REG_TIME_DIV;
	logic [CFG_DATA_W-1:0]       cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [SAMPLE_W-1:0]         adc_sample = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic                        kind;
	logic signed [VALUE_W-1:0]   value;
	logic [KEPT_W-1:0]           position;
	logic                        last;

	// model state of the block
	logic [TDIV_W-1:0]   tdiv_cfg = 5'd2;
	logic [VDIV_W-1:0]   vdiv_cfg = 8'd100;
	int                  cap_pos = 0;
	int                  dec_phase = 0;
	int                  kept_cnt = 0;
	int                  peak_hold = 0;

	scope_result_t       trace_peak_due[$];
	int                  mismatches = 0;
	int                  burst_left = 0;
	int                  hold_request = 0;
	int                  hold_left = 0;
	int                  mode_left = 0;
	rx_mode_e            rx_mode = RX_FREE;

	scope_capture_decimate_scale_peak_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.adc_sample (adc_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.value      (value),
		.position   (position),
		.last       (last)
	);

	always #10 clk = ~clk;

	function automatic logic [VALUE_W-1:0] trace_value(input logic [SAMPLE_W-1:0] s);
		int v;
		int num;
		int q;
		v = (vdiv_cfg == 0) ? 1 : int'(vdiv_cfg);
		num = (int'(s) - MIDSCALE) * TRACE_GAIN + TRACE_OFFSET * v;
		q = num / (256 * v);
		if (q > 2047)
			q = 2047;
		if (q < -2048)
			q = -2048;
		return q[VALUE_W-1:0];
	endfunction

	function automatic logic [VALUE_W-1:0] peak_value(input int p);
		int mv;
		int d;
		int r;
		mv = (p * 500) / 256;
		d = (mv > PEAK_OFFSET) ? mv - PEAK_OFFSET : 0;
		r = (44 * d) / 10;
		return r[VALUE_W-1:0];
	endfunction

	// advance the model by one accepted sample and queue the results it causes
	task automatic decimate_and_scale(input logic [SAMPLE_W-1:0] s);
		scope_result_t r;
		int step;
		if (tdiv_cfg == 0)
			step = 1;
		else if (tdiv_cfg > MAX_STEP)
			step = MAX_STEP;
		else
			step = int'(tdiv_cfg);
		if (int'(s) > peak_hold)
			peak_hold = int'(s);
		if (dec_phase == 0 && kept_cnt < DISPLAY_SAMPLES) begin
			r.kind = KIND_TRACE;
			r.value = trace_value(s);
			r.position = kept_cnt[KEPT_W-1:0];
			r.last = 1'b0;
			trace_peak_due.push_back(r);
			kept_cnt++;
		end
		if (dec_phase + 1 >= step)
			dec_phase = 0;
		else
			dec_phase++;
		cap_pos++;
		if (cap_pos >= CAPTURE_LEN) begin
			r.kind = KIND_PEAK;
			r.value = peak_value(peak_hold);
			r.position = '0;
			r.last = 1'b1;
			trace_peak_due.push_back(r);
			cap_pos = 0;
			dec_phase = 0;
			kept_cnt = 0;
			peak_hold = 0;
		end
	endtask

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_LIMIT)
			$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// offer one item, hold it until taken, then maybe open a gap
	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		in_valid <= 1'b1;
		adc_sample <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		decimate_and_scale(s);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
			burst_left = $urandom_range(0, 23);
		end
	endtask

	// drain the block, then write both registers
	task automatic set_config(input logic [CFG_DATA_W-1:0] tdiv_data,
			input logic [CFG_DATA_W-1:0] vdiv_data);
		in_valid <= 1'b0;
		while (trace_peak_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_TIME_DIV;
		cfg_data <= tdiv_data;
		@(posedge clk);
		cfg_index <= REG_VOLTS_DIV;
		cfg_data <= vdiv_data;
		@(posedge clk);
		cfg_we <= 1'b0;
		tdiv_cfg = tdiv_data[TDIV_W-1:0];
		vdiv_cfg = vdiv_data;
	endtask

	// fill the rest of the current capture; one sample hits the top of the range
	task automatic run_capture(input int lo, input int hi);
		int remaining;
		int peak_at;
		remaining = CAPTURE_LEN - cap_pos;
		peak_at = $urandom_range(0, remaining - 1);
		for (int i = 0; i < remaining; i++) begin
			if (i == peak_at)
				send_sample(hi[SAMPLE_W-1:0]);
			else
				send_sample(8'($urandom_range(lo, hi)));
		end
	endtask

	task automatic test_reset_defaults;
		send_sample(8'd0);
		send_sample(8'd255);
		send_sample(8'd128);
		send_sample(8'd127);
		send_sample(8'd129);
		send_sample(8'd1);
	endtask

	task automatic test_scale_extremes;
		set_config(8'd1, 8'd1);
		send_sample(8'd0);
		send_sample(8'd255);
		send_sample(8'd128);
		set_config(8'd1, 8'd255);
		send_sample(8'd0);
		send_sample(8'd255);
		// zero divisor and zero step
		set_config(8'd0, 8'd0);
		send_sample(8'd0);
		send_sample(8'd255);
		send_sample(8'd127);
	endtask

	task automatic test_step_limits;
		set_config(8'hFF, 8'd200);
		send_sample(8'hAA);
		send_sample(8'h55);
	endtask

	task automatic test_step_lowered;
		set_config(8'd16, 8'd100);
		while (dec_phase < 9)
			send_sample(8'($urandom));
		set_config(8'd3, 8'd100);
		repeat (4) send_sample(8'($urandom));
	endtask

	task automatic test_backpressure;
		set_config(8'd1, 8'd100);
		hold_request = 300;
		repeat (40) send_sample(8'($urandom));
	endtask

	task automatic test_full_display;
		set_config(8'd1, 8'd0);
		run_capture(0, 255);
	endtask

	task automatic test_quiet_peak;
		set_config(8'hFF, 8'd255);
		run_capture(0, 128);
	endtask

	task automatic test_peak_threshold;
		set_config(8'd2, 8'd100);
		run_capture(100, 129);
	endtask

	task automatic test_random_mix;
		int sent;
		int n;
		int t;
		int v;
		sample_style_e style;
		logic [SAMPLE_W-1:0] s;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 5))
				0: t = 0;
				1: t = 1;
				2: t = 16;
				3: t = 31;
				default: t = $urandom_range(0, 31);
			endcase
			case ($urandom_range(0, 4))
				0: v = 0;
				1: v = 1;
				2: v = 255;
				default: v = $urandom_range(0, 255);
			endcase
			set_config({3'($urandom), 5'(t)}, 8'(v));
			n = $urandom_range(20, 120);
			style = sample_style_e'($urandom_range(0, 3));
			repeat (n) begin
				case (style)
					SMP_UNIFORM: s = 8'($urandom);
					SMP_MIDSCALE: s = 8'($urandom_range(MIDSCALE - 8, MIDSCALE + 8));
					SMP_RAILS: s = $urandom_range(0, 1) ? 8'd255 : 8'd0;
					default: s = 8'($urandom_range(0, MIDSCALE));
				endcase
				send_sample(s);
			end
			sent += n;
		end
	endtask

	// receiver: long hold-off on request, otherwise a pattern of stall modes
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(1, 60);
			end
			mode_left--;
			case (rx_mode)
				RX_FREE: out_stall <= 1'b0;
				RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	always @(posedge clk) begin
		scope_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (trace_peak_due.size() == 0) begin
				report_mismatch($sformatf("unexpected item kind %0d value %0d pos %0d last %0d",
					kind, value, position, last));
			end else begin
				want = trace_peak_due.pop_front();
				if (kind !== want.kind || value !== want.value
						|| position !== want.position || last !== want.last)
					report_mismatch($sformatf(
						"got kind %0d value %0d pos %0d last %0d, want %0d %0d %0d %0d",
						kind, value, position, last, want.kind,
						$signed(want.value), want.position, want.last));
			end
		end
	end

	initial begin
		#25ms;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_scale_extremes();
		test_step_limits();
		test_step_lowered();
		test_backpressure();
		test_full_display();
		test_quiet_peak();
		test_peak_threshold();
		test_random_mix();
		in_valid <= 1'b0;
		while (trace_peak_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
